// ----- design/cpp_pkg.sv -----
`default_nettype none

package cpp_pkg;

   // The list of containers in use always has sixteen slots.
   localparam int SLOTS              = 16;
   localparam int SLOT_W             = 4;
   localparam int CNT_W              = 5;
   localparam int MAP_W              = 16;
   localparam int NUM_CONTAINERS_DEF = 16;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 5;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_POLICY_MODE     = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PROCESSOR_LIMIT = 1'b1;

   // Policy codes. Code zero and the unused code three both mean round robin.
   localparam logic [1:0] MODE_MIN = 2'd1;
   localparam logic [1:0] MODE_CAP = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT_MIN,
      OP_INIT_CAP,
      OP_INIT_RR,
      OP_STEP_MIN,
      OP_STEP_CAP,
      OP_STEP_RR,
      OP_APPEND_MAP,
      OP_APPEND_FRESH,
      OP_FAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic       out_free;
      logic       map_zero;
      logic       fresh_zero;
      logic       count_zero;
      logic       at_limit;
      logic [1:0] mode;
      logic       hit;
      logic       last;
   } sts_type;

   // Position of the lowest set bit; zero when no bit is set.
   function automatic logic [SLOT_W-1:0] lowest_set(input logic [MAP_W-1:0] bits);
      logic [SLOT_W-1:0] pos;
      pos = '0;
      for (int i = MAP_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = SLOT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// ----- design/cpp_ctrl.sv -----
`default_nettype none

module cpp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire cpp_pkg::sts_type sts,
   output cpp_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RR_PICK,
      ST_SCAN_MIN,
      ST_SCAN_CAP,
      ST_SCAN_RR,
      ST_APPEND,
      ST_FAIL
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = cpp_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = cpp_pkg::OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.out_free) begin
               priority if (sts.map_zero) begin
                  cmd.op   = cpp_pkg::OP_FAIL;
                  state_in = ST_IDLE;
               end else if (sts.mode == cpp_pkg::MODE_MIN) begin
                  if (sts.count_zero) begin
                     cmd.op   = cpp_pkg::OP_APPEND_MAP;
                     state_in = ST_IDLE;
                  end else begin
                     cmd.op   = cpp_pkg::OP_INIT_MIN;
                     state_in = ST_SCAN_MIN;
                  end
               end else if (sts.mode == cpp_pkg::MODE_CAP && sts.at_limit &&
                            !sts.count_zero) begin
                  cmd.op   = cpp_pkg::OP_INIT_CAP;
                  state_in = ST_SCAN_CAP;
               end else begin
                  state_in = ST_RR_PICK;
               end
            end
         end
         ST_RR_PICK: begin
            if (sts.out_free) begin
               priority if (!sts.fresh_zero) begin
                  cmd.op   = cpp_pkg::OP_APPEND_FRESH;
                  state_in = ST_IDLE;
               end else if (sts.count_zero) begin
                  cmd.op   = cpp_pkg::OP_FAIL;
                  state_in = ST_IDLE;
               end else begin
                  cmd.op   = cpp_pkg::OP_INIT_RR;
                  state_in = ST_SCAN_RR;
               end
            end
         end
         ST_SCAN_MIN: begin
            if (sts.out_free) begin
               cmd.op = cpp_pkg::OP_STEP_MIN;
               if (sts.hit) begin
                  state_in = ST_IDLE;
               end else if (sts.last) begin
                  state_in = ST_APPEND;
               end
            end
         end
         ST_SCAN_CAP: begin
            if (sts.out_free) begin
               cmd.op = cpp_pkg::OP_STEP_CAP;
               if (sts.hit) begin
                  state_in = ST_IDLE;
               end else if (sts.last) begin
                  state_in = ST_RR_PICK;
               end
            end
         end
         ST_SCAN_RR: begin
            if (sts.out_free) begin
               cmd.op = cpp_pkg::OP_STEP_RR;
               if (sts.hit) begin
                  state_in = ST_IDLE;
               end else if (sts.last) begin
                  state_in = ST_FAIL;
               end
            end
         end
         ST_APPEND: begin
            if (sts.out_free) begin
               cmd.op   = cpp_pkg::OP_APPEND_MAP;
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (sts.out_free) begin
               cmd.op   = cpp_pkg::OP_FAIL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/cpp_dpath.sv -----
`default_nettype none

module cpp_dpath #(
   parameter int NUM_CONTAINERS = cpp_pkg::NUM_CONTAINERS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [cpp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [cpp_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [cpp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [cpp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire cpp_pkg::cmd_type                  cmd,
   output cpp_pkg::sts_type                       sts
);

   localparam int MapBits = (NUM_CONTAINERS < cpp_pkg::MAP_W) ? NUM_CONTAINERS
                                                               : cpp_pkg::MAP_W;
   localparam logic [cpp_pkg::MAP_W-1:0] MapMask =
      {cpp_pkg::MAP_W{1'b1}} >> (cpp_pkg::MAP_W - MapBits);

   localparam int SW = cpp_pkg::SLOT_W;
   localparam int CW = cpp_pkg::CNT_W;
   localparam int MW = cpp_pkg::MAP_W;

   logic [MW-1:0] map_ff,   map_in;
   logic [MW-1:0] alloc_ff, alloc_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rot_ff,   rot_in;
   logic [SW-1:0] idx_ff,   idx_in;
   logic [CW-1:0] left_ff,  left_in;
   logic [1:0]    mode_ff,  mode_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic [SW-1:0] list_ff [cpp_pkg::SLOTS];

   logic          valid_ff,  valid_in;
   logic [SW-1:0] slot_ff,   slot_in;
   logic [SW-1:0] cont_ff,   cont_in;
   logic          added_ff,  added_in;
   logic          failed_ff, failed_in;

   logic [SW-1:0] entry;
   logic          hit;
   logic [CW-1:0] idx_inc;
   logic [SW-1:0] idx_wrap;
   logic [CW-1:0] rot_inc;
   logic [MW-1:0] fresh;
   logic [SW-1:0] pick;
   logic          list_we;
   logic          out_free;

   assign entry    = list_ff[idx_ff];
   assign hit      = map_ff[entry];
   assign idx_inc  = {1'b0, idx_ff} + CW'(1);
   assign idx_wrap = (idx_inc >= count_ff) ? '0 : idx_inc[SW-1:0];
   assign rot_inc  = rot_ff + CW'(1);
   assign fresh    = map_ff & ~alloc_ff;
   assign pick     = (cmd.op == cpp_pkg::OP_APPEND_FRESH) ? cpp_pkg::lowest_set(fresh)
                                                          : cpp_pkg::lowest_set(map_ff);
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      map_in    = map_ff;
      alloc_in  = alloc_ff;
      count_in  = count_ff;
      rot_in    = rot_ff;
      idx_in    = idx_ff;
      left_in   = left_ff;
      mode_in   = mode_ff;
      limit_in  = limit_ff;
      list_we   = 1'b0;
      valid_in  = valid_ff && !rsp_tready;
      slot_in   = slot_ff;
      cont_in   = cont_ff;
      added_in  = added_ff;
      failed_in = failed_ff;

      if (csr_we) begin
         unique case (csr_addr)
            cpp_pkg::CSR_POLICY_MODE:     mode_in  = csr_wdata[1:0];
            cpp_pkg::CSR_PROCESSOR_LIMIT: limit_in = csr_wdata;
            default:                      ;
         endcase
      end

      unique case (cmd.op)
         cpp_pkg::OP_LOAD: begin
            map_in = req_tdata[MW-1:0] & MapMask;
         end
         cpp_pkg::OP_INIT_MIN: begin
            idx_in  = '0;
            left_in = count_ff;
         end
         cpp_pkg::OP_INIT_CAP: begin
            idx_in  = (rot_ff >= count_ff) ? '0 : rot_ff[SW-1:0];
            left_in = count_ff;
         end
         cpp_pkg::OP_INIT_RR: begin
            idx_in  = (rot_inc >= count_ff) ? '0 : rot_inc[SW-1:0];
            left_in = count_ff;
         end
         cpp_pkg::OP_STEP_MIN, cpp_pkg::OP_STEP_CAP, cpp_pkg::OP_STEP_RR: begin
            // The cap scan leaves the pointer one past the slot it looked at,
            // unwrapped, whether or not that slot fits.
            if (cmd.op == cpp_pkg::OP_STEP_CAP) begin
               rot_in = idx_inc;
            end
            if (hit) begin
               if (cmd.op == cpp_pkg::OP_STEP_RR) begin
                  rot_in = {1'b0, idx_ff};
               end
               valid_in  = 1'b1;
               slot_in   = idx_ff;
               cont_in   = entry;
               added_in  = 1'b0;
               failed_in = 1'b0;
            end else begin
               idx_in  = idx_wrap;
               left_in = left_ff - CW'(1);
            end
         end
         cpp_pkg::OP_APPEND_MAP, cpp_pkg::OP_APPEND_FRESH: begin
            if (cmd.op == cpp_pkg::OP_APPEND_FRESH) begin
               rot_in = count_ff;
            end
            valid_in = 1'b1;
            if (count_ff[CW-1]) begin
               slot_in   = '0;
               cont_in   = '0;
               added_in  = 1'b0;
               failed_in = 1'b1;
            end else begin
               list_we   = 1'b1;
               alloc_in  = alloc_ff | (MW'(1) << pick);
               count_in  = count_ff + CW'(1);
               slot_in   = count_ff[SW-1:0];
               cont_in   = pick;
               added_in  = 1'b1;
               failed_in = 1'b0;
            end
         end
         cpp_pkg::OP_FAIL: begin
            valid_in  = 1'b1;
            slot_in   = '0;
            cont_in   = '0;
            added_in  = 1'b0;
            failed_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         count_ff <= '0;
         rot_ff   <= CW'(15);
         mode_ff  <= '0;
         limit_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         alloc_ff <= alloc_in;
         count_ff <= count_in;
         rot_ff   <= rot_in;
         mode_ff  <= mode_in;
         limit_ff <= limit_in;
         valid_ff <= valid_in;
      end
      map_ff    <= map_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      slot_ff   <= slot_in;
      cont_ff   <= cont_in;
      added_ff  <= added_in;
      failed_ff <= failed_in;
      if (list_we) begin
         list_ff[count_ff[SW-1:0]] <= pick;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(cpp_pkg::RSP_TDATA_W - 2 * SW - 2){1'b0}},
                        failed_ff, added_ff, cont_ff, slot_ff};

   always_comb begin
      sts.out_free   = out_free;
      sts.map_zero   = (map_ff == '0);
      sts.fresh_zero = (fresh == '0);
      sts.count_zero = (count_ff == '0);
      sts.at_limit   = (count_ff >= limit_ff);
      sts.mode       = mode_ff;
      sts.hit        = hit;
      sts.last       = (left_ff == CW'(1));
   end

   // Every container in the list is marked allocated exactly once.
   a_alloc_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(alloc_ff) == int'(count_ff))
      else $error("allocated map and used count disagree");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(cpp_pkg::SLOTS))
      else $error("used count beyond list size");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cpp_pkg::OP_APPEND_MAP || cmd.op == cpp_pkg::OP_APPEND_FRESH) &&
      !count_ff[CW-1] |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not grow the list");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff && failed_ff |-> slot_ff == '0 && cont_ff == '0 && !added_ff)
      else $error("failed result carries a placement");

endmodule

`default_nettype wire

// ----- design/container_placement_policy_unit.sv -----
`default_nettype none

// Container placement allocator. Each request item carries a map of the
// containers that can host it, and the block answers with one result item:
// the slot in its ordered list of containers in use, the container held
// there, whether that container was just appended, and a failure flag when
// no container fits (an empty map leaves all state alone). Round robin
// appends the lowest feasible unused container, or else rotates over the
// used slots; minimize reuses the first feasible used slot before appending;
// cap rotates over the used slots once the used count reaches the limit and
// otherwise behaves as round robin. A controller and a datapath search the used
// list one slot per clock cycle while the output register is free. Each item
// passes through load and decide, an optional round-robin pick, then a scan,
// an append or a failure, and its result may wait for rsp_tready.
// One item is handled at a time; a new item is taken while the previous
// result is still waiting at the output register. Configuration is to be
// written by the user only while no item is in flight; the block itself
// does not enforce this.
module container_placement_policy_unit #(
   parameter int NUM_CONTAINERS = cpp_pkg::NUM_CONTAINERS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] feasible_map
   input  wire logic [cpp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Result stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [3:0] slot_index, [7:4] container_id, [8] added_new, [9] failed,
   // [15:10] zero
   output logic [cpp_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // Configuration writes: index 0 policy_mode, index 1 processor_limit.
   input  wire logic                              csr_we,
   input  wire logic [cpp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [cpp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cpp_pkg::cmd_type cmd;
   cpp_pkg::sts_type sts;

   // The controller sequences decide, scan and append steps; it only issues
   // a step that may produce a result when the output register is free.
   cpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the used list, allocation map, rotation pointer,
   // configuration and the output register.
   cpp_dpath #(
      .NUM_CONTAINERS (NUM_CONTAINERS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

// ----- dv/placement_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, result and configuration ports of the placement unit,
// keeps its own copy of the allocator state and checks every result item
// against the placement predicted for the oldest open request.
module placement_checker
   import cpp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                    csr_we,
   input  wire logic [CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                           mismatches,
   output int                           outstanding,
   output int                           results_checked
);

   typedef struct packed {
      logic              failed;
      logic              added_new;
      logic [SLOT_W-1:0] container_id;
      logic [SLOT_W-1:0] slot_index;
   } placement_type;

   localparam placement_type REFUSED = '{1'b1, 1'b0, 4'd0, 4'd0};

   logic [SLOT_W-1:0] slot_list [SLOTS];
   logic [MAP_W-1:0]  taken_map;
   logic [CNT_W-1:0]  used_cnt;
   logic [CNT_W-1:0]  rot_ptr;
   logic [1:0]        policy;
   logic [CNT_W-1:0]  cap_limit;

   placement_type placements_due [$];

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic placement_type reuse_slot(input int slot);
      placement_type res;
      res = '0;
      res.slot_index   = SLOT_W'(slot);
      res.container_id = slot_list[slot];
      return res;
   endfunction

   // Appends the lowest container set in the map to the end of the list.
   function automatic placement_type append_lowest(input logic [MAP_W-1:0] map);
      placement_type res;
      res = REFUSED;
      if (used_cnt < SLOTS) begin
         for (int n = 0; n < MAP_W; n++) begin
            if (map[n]) begin
               slot_list[used_cnt[SLOT_W-1:0]] = SLOT_W'(n);
               taken_map[n] = 1'b1;
               res = '0;
               res.slot_index   = used_cnt[SLOT_W-1:0];
               res.container_id = SLOT_W'(n);
               res.added_new    = 1'b1;
               used_cnt = used_cnt + 1'b1;
               return res;
            end
         end
      end
      return res;
   endfunction

   function automatic placement_type round_robin(input logic [MAP_W-1:0] map);
      logic [MAP_W-1:0] fresh;
      int               r;
      fresh = map & ~taken_map;
      if (fresh != '0) begin
         rot_ptr = used_cnt;
         return append_lowest(fresh);
      end
      // Rotation wraps at the used count, so only written slots are read.
      r = rot_ptr;
      for (int k = 0; k < used_cnt; k++) begin
         r++;
         if (r >= used_cnt) begin
            r = 0;
         end
         if (map[slot_list[r]]) begin
            rot_ptr = CNT_W'(r);
            return reuse_slot(r);
         end
      end
      return REFUSED;
   endfunction

   function automatic placement_type predict_placement(input logic [MAP_W-1:0] map);
      int r;
      if (map == '0) begin
         return REFUSED;
      end
      if (policy == MODE_MIN) begin
         for (int n = 0; n < used_cnt; n++) begin
            if (map[slot_list[n]]) begin
               return reuse_slot(n);
            end
         end
         return append_lowest(map);
      end
      if (policy == MODE_CAP && used_cnt >= cap_limit) begin
         // A miss here leaves the pointer where the scan ended.
         for (int n = 0; n < used_cnt; n++) begin
            if (rot_ptr >= used_cnt) begin
               rot_ptr = '0;
            end
            r = rot_ptr;
            rot_ptr = rot_ptr + 1'b1;
            if (map[slot_list[r]]) begin
               return reuse_slot(r);
            end
         end
      end
      return round_robin(map);
   endfunction

   always @(posedge clock) begin : watch
      placement_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_list[i] = '0;
         end
         taken_map = '0;
         used_cnt  = '0;
         rot_ptr   = CNT_W'(15);
         policy    = '0;
         cap_limit = '0;
         placements_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_POLICY_MODE) begin
               policy = csr_wdata[1:0];
            end else if (csr_addr == CSR_PROCESSOR_LIMIT) begin
               cap_limit = csr_wdata;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (placements_due.size() == 0) begin
               report_mismatch($sformatf("result item %h with no request open", rsp_tdata));
            end else begin
               want = placements_due.pop_front();
               results_checked++;
               if (rsp_tdata[3:0] != want.slot_index)
                  report_mismatch($sformatf("slot_index got %0d expected %0d",
                                            rsp_tdata[3:0], want.slot_index));
               if (rsp_tdata[7:4] != want.container_id)
                  report_mismatch($sformatf("container_id got %0d expected %0d",
                                            rsp_tdata[7:4], want.container_id));
               if (rsp_tdata[8] != want.added_new)
                  report_mismatch($sformatf("added_new got %0d expected %0d",
                                            rsp_tdata[8], want.added_new));
               if (rsp_tdata[9] != want.failed)
                  report_mismatch($sformatf("failed got %0d expected %0d",
                                            rsp_tdata[9], want.failed));
               if (rsp_tdata[15:10] != '0)
                  report_mismatch($sformatf("padding bits got %h", rsp_tdata[15:10]));
            end
         end
         if (req_tvalid && req_tready) begin
            placements_due.push_back(predict_placement(req_tdata[MAP_W-1:0]));
         end
      end
      outstanding <= placements_due.size();
   end

endmodule

// ----- dv/container_placement_policy_unit_tb.sv -----
`timescale 1ns / 100ps

// Top of the placement unit testbench. It builds the request stimulus,
// toggles the handshakes and walks the policy registers through their
// settings; all prediction and comparison lives in the checker.
module container_placement_policy_unit_tb;
   import cpp_pkg::*;

   // Round robin has two codes: zero and the otherwise unused code three.
   localparam logic [1:0] MODE_RR     = 2'd0;
   localparam logic [1:0] MODE_RR_ALT = 2'd3;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   int mismatches;
   int outstanding;
   int results_checked;

   // Idle percentages for the two sides; they change as the run goes on.
   int send_idle_pct = 31;
   int recv_idle_pct = 85;
   int sent_items    = 0;
   int settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   container_placement_policy_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   placement_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // The result side stalls at random, one fresh decision every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Drops the request valid and waits until every open request has had its
   // result item accepted. The first edge is taken unconditionally so that
   // the checker's count already includes an item accepted at this edge.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes the mode register and then the limit register with the block idle.
   task automatic set_policy(input logic [1:0] mode, input int limit);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_POLICY_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_addr  <= CSR_PROCESSOR_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   // Offers one request item and holds it until the block takes it. Valid is
   // only lowered when an idle cycle is inserted, so back-to-back items keep
   // it high without a second assignment in the same step.
   task automatic place(input logic [MAP_W-1:0] map);
      if (sent_items < 160) begin
         send_idle_pct = 31;
         recv_idle_pct = 85;
      end else if (sent_items < 320) begin
         send_idle_pct = 85;
         recv_idle_pct = 31;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= map;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sent_items++;
   endtask

   // Random maps lean toward one or two feasible containers, so the used list
   // grows slowly and the reuse and rotation paths get plenty of traffic.
   // Full maps, empty maps and fully random maps make up the rest.
   function automatic logic [MAP_W-1:0] random_map();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         return MAP_W'(1) << $urandom_range(MAP_W - 1);
      if (pick < 70)
         return (MAP_W'(1) << $urandom_range(MAP_W - 1)) |
                (MAP_W'(1) << $urandom_range(MAP_W - 1));
      if (pick < 76)
         return '1;
      if (pick < 82)
         return '0;
      return MAP_W'($urandom);
   endfunction

   task automatic random_phase(input logic [1:0] mode, input int limit, input int count);
      set_policy(mode, limit);
      repeat (count) begin
         place(random_map());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Reset defaults first: an empty map must fail without
      // touching state, then the two extreme containers get appended.
      place(16'h0000);
      place(16'h0001);
      place(16'h8000);

      // Cap mode below its limit behaves as round robin, first by rotation
      // and then by appending; at the limit it rotates over used slots, and
      // a map with no used container that fits falls back to an append.
      set_policy(MODE_CAP, 4);
      place(16'h0001);
      place(16'h0006);
      place(16'h0030);
      place(16'h8001);
      place(16'h8001);
      place(16'h0100);
      place(16'hFFFF);
      place(16'h0000);

      // Minimize reuses the first used slot that fits before appending.
      set_policy(MODE_MIN, 16);
      place(16'h8000);
      place(16'hFFFF);
      place(16'h0200);
      place(16'h0000);

      // The unused mode code must act as round robin.
      set_policy(MODE_RR_ALT, 0);
      place(16'h8001);
      place(16'h8001);
      place(16'h0400);
      place(16'hAAAA);
      place(16'h5555);

      // Random part over a spread of settings, limit extremes included.
      random_phase(MODE_CAP,    16, 60);
      random_phase(MODE_MIN,     0, 55);
      random_phase(MODE_RR,     16, 55);
      random_phase(MODE_CAP,     0, 55);
      random_phase(MODE_RR_ALT,  5, 50);
      random_phase(MODE_CAP,     8, 60);
      random_phase(MODE_MIN,    16, 55);
      random_phase(MODE_CAP,    16, 60);

      // Drain, then give the block time to show any stray result item.
      wait_idle();
      repeat (25) @(posedge clock);

      $display("Run covered %0d request items under %0d register settings,",
               sent_items, settings_used);
      $display("all four mode codes and limits from 0 to 16; %0d results compared.",
               results_checked);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run with the longest stalls.
   initial begin
      #5000000;
      $display("Timeout with %0d result items still open.", outstanding);
      $display("status: fail");
      $finish;
   end

endmodule
